>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Types, codes and helpers shared by the leader election block.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int MAX_MEMBERS = 16;
  localparam int CNT_LIM     = (MAX_MEMBERS < 16) ? MAX_MEMBERS : 16;
  localparam int ID_W        = 4;
  localparam int CNT_W       = 5;
  localparam int MASK_W      = 16;
  localparam int TICK_W      = 32;
  localparam int EXTRA_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  // input event kinds
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_PROPOSE = 3'd1;
  localparam logic [2:0] MODE_ACK     = 3'd2;
  localparam logic [2:0] MODE_VICTORY = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  // result actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_PROPOSE = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_WON     = 3'd3;
  localparam logic [2:0] ACT_LOST    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ID        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFER_EXTRA  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_PROPOSE = 3'd2,
    OP_ACK     = 3'd3,
    OP_VICTORY = 3'd4,
    OP_TICK    = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] from_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ID_W-1:0]   target_id;
    logic [MASK_W-1:0] ack_mask;
    logic              electing;
  } out_word_t;

  typedef struct packed {
    op_kind_t        op;
    logic [ID_W-1:0] from_id;
  } op_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    my_id;
    logic [CNT_W-1:0]   member_count;
    logic [TICK_W-1:0]  lease_ticks;
    logic [EXTRA_W-1:0] defer_extra_ticks;
  } cfg_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/rank_leader_election.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_leader_election
// Leader election among up to 16 ranked members; lower rank wins.
// Path: an accepted event word is stored in a queue entry register, and its
// result word is then registered in the output register of the back stage.
// Throughput: one event word per cycle while out_ready holds, set by the state
// update in the back stage; a two-entry queue decouples input from output stalls.
// Reset: synchronous, active low; clears election state, queue and output,
// and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module rank_leader_election (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rle_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rle_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [rle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rle_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  rle_pkg::cfg_t     cfg_r;
  logic              push_valid, push_ready;
  rle_pkg::op_word_t push_op;
  logic              pop_valid, pop_ready;
  rle_pkg::op_word_t pop_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_id             <= '0;
      cfg_r.member_count      <= rle_pkg::CNT_W'(1);
      cfg_r.lease_ticks       <= rle_pkg::TICK_W'(1000);
      cfg_r.defer_extra_ticks <= rle_pkg::EXTRA_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rle_pkg::CFG_MY_ID:        cfg_r.my_id <= cfg_wdata[rle_pkg::ID_W-1:0];
        rle_pkg::CFG_MEMBER_COUNT: cfg_r.member_count <= cfg_wdata[rle_pkg::CNT_W-1:0];
        rle_pkg::CFG_LEASE_TICKS:  cfg_r.lease_ticks <= cfg_wdata[rle_pkg::TICK_W-1:0];
        rle_pkg::CFG_DEFER_EXTRA:  cfg_r.defer_extra_ticks <= cfg_wdata[rle_pkg::EXTRA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rle_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  rle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  rle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_front
// Accepts event words and decodes the mode into an operation for the queue.
// ----------------------------------------------------------------------------
module rle_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rle_pkg::in_word_t    in_data,
  output logic                 push_valid,
  input  logic                 push_ready,
  output rle_pkg::op_word_t    push_op
);

  rle_pkg::op_kind_t op;

  always_comb begin
    unique case (in_data.mode)
      rle_pkg::MODE_START:   op = rle_pkg::OP_START;
      rle_pkg::MODE_PROPOSE: op = rle_pkg::OP_PROPOSE;
      rle_pkg::MODE_ACK:     op = rle_pkg::OP_ACK;
      rle_pkg::MODE_VICTORY: op = rle_pkg::OP_VICTORY;
      rle_pkg::MODE_TICK:    op = rle_pkg::OP_TICK;
      default:               op = rle_pkg::OP_NONE;
    endcase
  end

  assign push_valid      = in_valid;
  assign in_ready        = push_ready;
  assign push_op.op      = op;
  assign push_op.from_id = in_data.from_id;

endmodule

>>> rtl/core/rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module rle_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  rle_pkg::op_word_t push_op,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rle_pkg::op_word_t pop_op
);

  localparam int QPTR_W = (rle_pkg::QUEUE_DEPTH > 1) ? $clog2(rle_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(rle_pkg::QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(rle_pkg::QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(rle_pkg::QUEUE_DEPTH);

  rle_pkg::op_word_t entry_r [rle_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> rtl/core/rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_back
// Election state update for one operation per cycle while the output register is free or taken.
// ----------------------------------------------------------------------------
module rle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rle_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  rle_pkg::op_word_t  pop_op,
  output logic               out_valid,
  input  logic               out_ready,
  output rle_pkg::out_word_t out_data
);

  localparam int ID_W   = rle_pkg::ID_W;
  localparam int CNT_W  = rle_pkg::CNT_W;
  localparam int MASK_W = rle_pkg::MASK_W;
  localparam int TICK_W = rle_pkg::TICK_W;
  localparam logic [CNT_W-1:0] LIM = CNT_W'(rle_pkg::CNT_LIM);

  logic                bid_r, bid_nxt;
  logic                dv_r, dv_nxt;
  logic [ID_W-1:0]     dto_r, dto_nxt;
  logic [MASK_W-1:0]   acked_r, acked_nxt;
  logic                trun_r, trun_nxt;
  logic [TICK_W-1:0]   tleft_r, tleft_nxt;
  logic                out_valid_r;
  rle_pkg::out_word_t  out_data_r, res;

  logic [CNT_W-1:0]    cnt;
  logic [MASK_W-1:0]   acked_or;
  logic [TICK_W-1:0]   tl_dec;
  logic [TICK_W:0]     defer_sum;
  logic [TICK_W-1:0]   defer_load;
  logic [ID_W-1:0]     from;
  logic [2:0]          action;
  logic [ID_W-1:0]     target;
  logic                do_start, do_vic, do_defer, fire;

  assign pop_ready = !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign from      = pop_op.from_id;

  // clamp member count to 1..limit
  always_comb begin
    if (cfg.member_count == '0) begin
      cnt = CNT_W'(1);
    end else if (cfg.member_count > LIM) begin
      cnt = LIM;
    end else begin
      cnt = cfg.member_count;
    end
  end

  assign acked_or   = acked_r | (MASK_W'(1) << from);
  assign tl_dec     = (tleft_r != '0) ? tleft_r - 1'b1 : '0;
  assign defer_sum  = {1'b0, cfg.lease_ticks} + (TICK_W + 1)'(cfg.defer_extra_ticks);
  assign defer_load = defer_sum[TICK_W] ? '1 : defer_sum[TICK_W-1:0];

  always_comb begin
    bid_nxt   = bid_r;
    dv_nxt    = dv_r;
    dto_nxt   = dto_r;
    acked_nxt = acked_r;
    trun_nxt  = trun_r;
    tleft_nxt = tleft_r;
    action    = rle_pkg::ACT_NONE;
    target    = '0;
    do_start  = 1'b0;
    do_vic    = 1'b0;
    do_defer  = 1'b0;

    unique case (pop_op.op)
      rle_pkg::OP_START: begin
        do_start = 1'b1;
      end
      rle_pkg::OP_PROPOSE: begin
        if (from > cfg.my_id) begin
          do_start = !bid_r;
        end else if (!dv_r || dto_r >= from) begin
          do_defer = 1'b1;
          target   = from;
        end
      end
      rle_pkg::OP_ACK: begin
        if (bid_r && {1'b0, from} < cnt) begin
          acked_nxt = acked_or;
          do_vic    = (rle_pkg::popcount(acked_or) == cnt);
        end
      end
      rle_pkg::OP_VICTORY: begin
        if (from < cfg.my_id) begin
          trun_nxt = 1'b0;
          action   = rle_pkg::ACT_LOST;
          target   = from;
        end else begin
          do_start = 1'b1;
        end
      end
      rle_pkg::OP_TICK: begin
        if (trun_r) begin
          tleft_nxt = tl_dec;
          if (tl_dec == '0) begin
            trun_nxt = 1'b0;
            // majority win on expiry, otherwise bid again
            if (bid_r && rle_pkg::popcount(acked_r) > (cnt >> 1)) begin
              do_vic = 1'b1;
            end else begin
              do_start = 1'b1;
            end
          end
        end
      end
      rle_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase

    if (do_start) begin
      dv_nxt    = 1'b0;
      acked_nxt = MASK_W'(1) << cfg.my_id;
      bid_nxt   = 1'b1;
      tleft_nxt = cfg.lease_ticks;
      trun_nxt  = 1'b1;
      action    = rle_pkg::ACT_PROPOSE;
    end
    if (do_vic) begin
      dv_nxt   = 1'b0;
      bid_nxt  = 1'b0;
      trun_nxt = 1'b0;
      action   = rle_pkg::ACT_WON;
    end
    if (do_defer) begin
      if (bid_r) begin
        acked_nxt = '0;
        bid_nxt   = 1'b0;
      end
      dv_nxt    = 1'b1;
      dto_nxt   = from;
      tleft_nxt = defer_load;
      trun_nxt  = 1'b1;
      action    = rle_pkg::ACT_ACK;
    end

    res.action    = action;
    res.target_id = target;
    res.ack_mask  = (action == rle_pkg::ACT_WON) ? acked_nxt : '0;
    res.electing  = bid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_r       <= 1'b0;
      dv_r        <= 1'b0;
      dto_r       <= '0;
      acked_r     <= '0;
      trun_r      <= 1'b0;
      tleft_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        bid_r   <= bid_nxt;
        dv_r    <= dv_nxt;
        dto_r   <= dto_nxt;
        acked_r <= acked_nxt;
        trun_r  <= trun_nxt;
        tleft_r <= tleft_nxt;
      end
      // hold the result word until taken
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

endmodule

>>> rtl/core/rle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_checker
// Port-level checks on result words of the leader election block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input rle_pkg::out_word_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_won_not_electing, out_valid && out_data.action == rle_pkg::ACT_WON, !out_data.electing)
  `ASSERT_IMPL(a_propose_electing, out_valid && out_data.action == rle_pkg::ACT_PROPOSE, out_data.electing)
  `ASSERT_IMPL(a_ack_not_electing, out_valid && out_data.action == rle_pkg::ACT_ACK, !out_data.electing)
  `ASSERT_IMPL(a_mask_only_on_win, out_valid && out_data.action != rle_pkg::ACT_WON, out_data.ack_mask == '0)

endmodule

bind rank_leader_election rle_checker u_rle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
